/* design/tpr_pkg.sv */
// shared types, constants and table builders for the torus point raster frame core
// no dependencies; used by every module of the design
`default_nettype none

package tpr_pkg;

  // request operation codes
  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // shade codes and characters
  localparam logic [3:0] BLANK_CODE = 4'd15;
  localparam logic [3:0] SHADE_MAX  = 4'd11;
  localparam logic [6:0] SPACE_CHAR = 7'h20;

  // sweep limits: 63 tube angles, 629 ring angles
  localparam logic [5:0] TUBE_LAST = 6'd62;
  localparam logic [9:0] RING_LAST = 10'd628;

  // cell address width, covers the largest screen
  localparam int ADDR_W = 15;

  // trig table depth, one entry per 10-bit angle code
  localparam int TRIG_DEPTH = 1024;

  // angle constants in Q30
  localparam longint unsigned Q30_PI      = 64'd3373259426;
  localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  typedef struct packed {
    logic        operation;
    logic [9:0]  angle_a;
    logic [9:0]  angle_b;
    logic [11:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [6:0] cell_char;
    logic       frame_done;
  } rsp_t;

  // what the trig rom read feeds, travels with the read data
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_t;
    logic point;
  } trig_ctl_t;

  // one candidate point for the frame store
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
    logic [15:0]       depth;
    logic [3:0]        shade;
  } pt_write_t;

  typedef logic signed [31:0] trig_tab_t [TRIG_DEPTH];

  // sine of a nonnegative Q30 angle, rounded to Q(frac)
  // taylor terms up to x^25, each divided by (2k)(2k+1)
  function automatic logic signed [31:0] sin_fixed(input longint unsigned xin, input int frac);
    logic neg;
    longint unsigned x, x2, term, sum, r;
    x = xin % Q30_TWO_PI;
    neg = 1'b0;
    if (x >= Q30_PI) begin
      neg = 1'b1;
      x = x - Q30_PI;
    end
    if (x > Q30_HALF_PI) x = Q30_PI - x;
    x2 = (x * x) >> 30;
    sum = x;
    term = ((x * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd342;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd420;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd506;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd600;
    sum = sum + term;
    r = (sum + (64'd1 << (29 - frac))) >> (30 - frac);
    return neg ? -32'(r) : 32'(r);
  endfunction

  // sin or cos of n hundredths of a radian for every angle code
  function automatic trig_tab_t build_trig_tab(input int frac, input logic is_cos);
    trig_tab_t tab;
    longint unsigned x;
    for (int n = 0; n < TRIG_DEPTH; n++) begin
      x = (longint'(n) << 30) / 100;
      if (is_cos) x = x + Q30_HALF_PI;
      tab[n] = sin_fixed(x, frac);
    end
    return tab;
  endfunction

  function automatic logic [6:0] shade_char(input logic [3:0] code);
    logic [6:0] c;
    case (code)
      4'd0:    c = 7'h2E;
      4'd1:    c = 7'h2C;
      4'd2:    c = 7'h2D;
      4'd3:    c = 7'h7E;
      4'd4:    c = 7'h3A;
      4'd5:    c = 7'h3B;
      4'd6:    c = 7'h3D;
      4'd7:    c = 7'h21;
      4'd8:    c = 7'h2A;
      4'd9:    c = 7'h23;
      4'd10:   c = 7'h24;
      4'd11:   c = 7'h40;
      default: c = SPACE_CHAR;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/tpr_trig_rom.sv */
// sine and cosine rom over all angle codes, registered read
// depends on tpr_pkg
`default_nettype none

module tpr_trig_rom #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [9:0]                   addr,
  input  wire tpr_pkg::trig_ctl_t           ctl,
  output logic signed [FRAC_BITS+1:0]       sin_q,
  output logic signed [FRAC_BITS+1:0]       cos_q,
  output tpr_pkg::trig_ctl_t                ctl_q
);

  localparam int TW = FRAC_BITS + 2;
  localparam tpr_pkg::trig_tab_t SIN_TAB = tpr_pkg::build_trig_tab(FRAC_BITS, 1'b0);
  localparam tpr_pkg::trig_tab_t COS_TAB = tpr_pkg::build_trig_tab(FRAC_BITS, 1'b1);

  always_ff @(posedge clk) begin
    sin_q <= TW'(SIN_TAB[addr]);
    cos_q <= TW'(COS_TAB[addr]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

endmodule

`default_nettype wire

/* design/tpr_point_pipe.sv */
// point engine: rotation, projection divider and screen mapping, one point per cycle
// depends on tpr_pkg; fed by tpr_trig_rom
`default_nettype none

module tpr_point_pipe #(
  parameter int COLS      = 100,
  parameter int ROWS      = 40,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tpr_pkg::trig_ctl_t         ctl,
  input  wire logic signed [FRAC_BITS+1:0] sin_v,
  input  wire logic signed [FRAC_BITS+1:0] cos_v,
  output tpr_pkg::pt_write_t              wr,
  output logic                            front_busy,
  output logic                            busy
);

  localparam int VW = FRAC_BITS + 5;
  localparam int PW = VW + 17;
  localparam int SH = FRAC_BITS + 16;
  localparam int NW = FRAC_BITS + 28;
  localparam int XW = $clog2(COLS);
  localparam int YW = $clog2(ROWS);
  localparam int DIV_STAGES = 16;
  localparam int AW = tpr_pkg::ADDR_W;

  localparam logic signed [VW-1:0] ONE_V  = VW'(longint'(1) << FRAC_BITS);
  localparam logic signed [VW-1:0] TWO_V  = VW'(longint'(2) << FRAC_BITS);
  localparam logic signed [VW-1:0] FIVE_V = VW'(longint'(5) << FRAC_BITS);
  localparam logic signed [2*VW-1:0] RND_V = (2*VW)'((longint'(1) << FRAC_BITS) - 1);
  localparam logic signed [NW-1:0] HALF_W_S = NW'(longint'(COLS / 2) << SH);
  localparam logic signed [NW-1:0] HALF_H_S = NW'(longint'(ROWS / 2) << SH);
  localparam logic signed [NW-1:0] ONE_S    = NW'(longint'(1) << SH);

  // fixed-point product, truncated toward zero
  function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = a * b;
    if (p < 0) p = p + RND_V;
    return VW'(p >>> FRAC_BITS);
  endfunction

  // rotation and tube constants
  logic signed [VW-1:0] sa, ca, sb, cb, sasb, sacb, casb, cacb;
  logic signed [VW-1:0] st, ct, cx, tx, ty, tz, cacx, cact, cast, ctsa;
  logic signed [VW-1:0] sp, cp;

  assign sp = VW'(sin_v);
  assign cp = VW'(cos_v);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      sa <= VW'(sin_v);
      ca <= VW'(cos_v);
    end
    if (ctl.load_b) begin
      sb <= VW'(sin_v);
      cb <= VW'(cos_v);
    end
    if (ctl.load_t) begin
      st <= VW'(sin_v);
      ct <= VW'(cos_v);
    end
    sasb <= mulq(sa, sb);
    sacb <= mulq(sa, cb);
    casb <= mulq(ca, sb);
    cacb <= mulq(ca, cb);
    cx   <= ct + TWO_V;
    tx   <= mulq(st, casb);
    ty   <= mulq(st, cacb);
    tz   <= mulq(st, sa);
    cacx <= mulq(ca, ct + TWO_V);
    cact <= mulq(ca, ct);
    cast <= mulq(ca, st);
    ctsa <= mulq(ct, sa);
  end

  // stage 1 products of the ring angle
  logic v1, v2, v3;
  logic signed [VW-1:0] m1, m2, m3, m4, m5, m6, m7, m8;
  // stage 2 sums
  logic signed [VW-1:0] sx, sy, sl, z2, p6, p7;
  // stage 3 rotated point and light terms
  logic signed [VW-1:0] x3, y3, la, lb, z3, q7;
  logic signed [VW-1:0] l4, lsh;
  logic [3:0] lum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctl.point;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    m1 <= mulq(cb, cp);
    m2 <= mulq(sasb, sp);
    m3 <= mulq(sb, cp);
    m4 <= mulq(sacb, sp);
    m5 <= mulq(cacx, sp);
    m6 <= mulq(cp, ct);
    m7 <= mulq(cact, sp);
    m8 <= mulq(ctsa, sp);
    sx <= m1 + m2;
    sy <= m3 - m4;
    sl <= cast - m8;
    z2 <= FIVE_V + m5 + tz;
    p6 <= m6;
    p7 <= m7;
    x3 <= mulq(cx, sx) - tx;
    y3 <= mulq(cx, sy) + ty;
    la <= mulq(p6, sb);
    lb <= mulq(cb, sl);
    z3 <= z2;
    q7 <= p7;
  end

  // shade: trunc(8*l) clamped to 0..11
  always_comb begin
    l4  = la - q7 - tz + lb;
    lsh = l4 >>> (FRAC_BITS - 3);
    if (l4 < 0) lum4 = 4'd0;
    else if (lsh > VW'(tpr_pkg::SHADE_MAX)) lum4 = tpr_pkg::SHADE_MAX;
    else lum4 = lsh[3:0];
  end

  // restoring divider for 2^(FRAC_BITS+16)/z, one quotient bit per stage
  logic                 dv   [DIV_STAGES+1];
  logic [VW-1:0]        dr   [DIV_STAGES+1];
  logic [15:0]          dq   [DIV_STAGES+1];
  logic [VW-1:0]        dz   [DIV_STAGES+1];
  logic signed [VW-1:0] dx   [DIV_STAGES+1];
  logic signed [VW-1:0] dy   [DIV_STAGES+1];
  logic [3:0]           dlum [DIV_STAGES+1];
  logic                 dsat [DIV_STAGES+1];

  // points behind the eye are dropped; z at or below one saturates the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v3 && (z3 > 0);
    end
  end

  always_ff @(posedge clk) begin
    dr[0]   <= VW'(ONE_V);
    dq[0]   <= '0;
    dz[0]   <= VW'(z3);
    dx[0]   <= x3;
    dy[0]   <= y3;
    dlum[0] <= lum4;
    dsat[0] <= (z3 <= ONE_V);
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [VW:0] r2;
    logic        ge;
    assign r2 = {dr[i], 1'b0};
    assign ge = (r2 >= {1'b0, dz[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      dr[i+1]   <= ge ? VW'(r2 - {1'b0, dz[i]}) : VW'(r2);
      dq[i+1]   <= {dq[i][14:0], ge};
      dz[i+1]   <= dz[i];
      dx[i+1]   <= dx[i];
      dy[i+1]   <= dy[i];
      dlum[i+1] <= dlum[i];
      dsat[i+1] <= dsat[i];
    end
  end

  // projection
  logic [15:0] ooz;
  logic        va, vb, vc;
  logic signed [PW-1:0] px, py;
  logic [15:0] ooz_a, ooz_b;
  logic [3:0]  lum_a, lum_b;
  logic signed [NW-1:0] nx, ny;
  logic        on_screen;
  logic [XW-1:0] xb;
  logic [YW-1:0] yb;
  logic [AW-1:0] idx_c;
  logic [15:0]   ooz_c;
  logic [3:0]    lum_c;

  assign ooz = dsat[DIV_STAGES] ? 16'hFFFF : dq[DIV_STAGES];

  always_comb begin
    nx = HALF_W_S + (NW'(px) <<< 5) + (NW'(px) <<< 3);
    ny = HALF_H_S - (NW'(py) <<< 4) - (NW'(py) <<< 2);
    // strictly inside: both coordinates at least one and below the edge
    on_screen = (nx >= ONE_S) && ((nx >>> SH) < NW'(COLS)) &&
                (ny >= ONE_S) && ((ny >>> SH) < NW'(ROWS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= dv[DIV_STAGES];
      vb <= va && on_screen;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    px    <= PW'(dx[DIV_STAGES]) * PW'($signed({1'b0, ooz}));
    py    <= PW'(dy[DIV_STAGES]) * PW'($signed({1'b0, ooz}));
    ooz_a <= ooz;
    lum_a <= dlum[DIV_STAGES];
    xb    <= nx[SH +: XW];
    yb    <= ny[SH +: YW];
    ooz_b <= ooz_a;
    lum_b <= lum_a;
    idx_c <= AW'(xb) + AW'(yb) * AW'(COLS);
    ooz_c <= ooz_b;
    lum_c <= lum_b;
  end

  logic div_busy;
  always_comb begin
    div_busy = 1'b0;
    for (int i = 0; i <= DIV_STAGES; i++) div_busy = div_busy | dv[i];
  end

  assign wr.valid = vc;
  assign wr.idx   = idx_c;
  assign wr.depth = ooz_c;
  assign wr.shade = lum_c;

  assign front_busy = ctl.point | v1 | v2 | v3;
  assign busy       = front_busy | div_busy | va | vb | vc;

endmodule

`default_nettype wire

/* design/tpr_frame_mem.sv */
// frame store: depth and shade per cell in one ram, depth test with write forwarding
// depends on tpr_pkg; fed by tpr_point_pipe
`default_nettype none

module tpr_frame_mem #(
  parameter int CELLS = 4000
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clr_we,
  input  wire logic [tpr_pkg::ADDR_W-1:0]  clr_addr,
  input  wire tpr_pkg::pt_write_t          wr,
  input  wire logic [tpr_pkg::ADDR_W-1:0]  rd_addr,
  output logic [3:0]                       rd_shade,
  output logic                             busy
);

  localparam int AW = $clog2(CELLS);
  localparam int IW = tpr_pkg::ADDR_W;

  // word: depth in the upper 16 bits, shade code below
  logic [19:0] mem [CELLS];
  logic [19:0] rdata;
  logic [IW-1:0] raddr;

  logic          m1_v;
  logic [IW-1:0] m1_idx;
  logic [15:0]   m1_depth;
  logic [3:0]    m1_shade;

  logic          fw_v;
  logic [IW-1:0] fw_idx;
  logic [15:0]   fw_depth;

  logic [15:0] cur_depth;
  logic        hit;

  assign raddr = wr.valid ? wr.idx : rd_addr;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr[AW-1:0]];
  end

  // the previous point's write lands at the edge of this read, so take it from here
  always_comb begin
    cur_depth = (fw_v && fw_idx == m1_idx) ? fw_depth : rdata[19:4];
    hit = m1_v && (m1_depth > cur_depth);
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem[clr_addr[AW-1:0]] <= {16'd0, tpr_pkg::BLANK_CODE};
    end else if (hit) begin
      mem[m1_idx[AW-1:0]] <= {m1_depth, m1_shade};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      fw_v <= 1'b0;
    end else begin
      m1_v <= wr.valid;
      fw_v <= hit;
    end
  end

  always_ff @(posedge clk) begin
    m1_idx   <= wr.idx;
    m1_depth <= wr.depth;
    m1_shade <= wr.shade;
    fw_idx   <= m1_idx;
    fw_depth <= m1_depth;
  end

  assign rd_shade = rdata[3:0];
  assign busy     = m1_v;

endmodule

`default_nettype wire

/* design/torus_point_raster_frame_core.sv */
// top level of the torus point raster frame core: request sequencer and result register
// depends on tpr_pkg, tpr_trig_rom, tpr_point_pipe and tpr_frame_mem
//
//   channel   handshake            payload  notes
//   request   start / busy         req      taken when start is high and busy is low
//   result    result_valid strobe  result   one cycle per result, cannot be held off
//
// a read request is busy after accept for one ram read (ST_READ), then the character
// lookup into the output register (ST_READ_OUT); its result strobes in the next cycle
// a render request clears the frame ram one cell a cycle, then steps through the rotation
// trig states (ST_TRIG_A, ST_TRIG_B, ST_ROT), then for each of 63 tube angles: one rom
// read, a settle state, 629 ring points at one per cycle and a drain of the front
// stages; a flush through divider, projection and ram follows
// after reset the same clearing pass runs with busy high
// results are strobed and never stall, so nothing inside waits on the receiver
`default_nettype none

module torus_point_raster_frame_core #(
  parameter int COLS      = 100,
  parameter int ROWS      = 40,
  parameter int FRAC_BITS = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tpr_pkg::req_t req,
  output logic               result_valid,
  output tpr_pkg::rsp_t      result
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = tpr_pkg::ADDR_W;
  localparam int TW    = FRAC_BITS + 2;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_CLEAR     = 12'b0000_0000_0010,
    ST_TRIG_A    = 12'b0000_0000_0100,
    ST_TRIG_B    = 12'b0000_0000_1000,
    ST_ROT       = 12'b0000_0001_0000,
    ST_TUBE_RD   = 12'b0000_0010_0000,
    ST_TUBE_WAIT = 12'b0000_0100_0000,
    ST_SWEEP     = 12'b0000_1000_0000,
    ST_DRAIN     = 12'b0001_0000_0000,
    ST_FLUSH     = 12'b0010_0000_0000,
    ST_READ      = 12'b0100_0000_0000,
    ST_READ_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  logic          boot;       // clearing pass after reset, no render follows
  logic [AW-1:0] clr_cnt;
  logic [5:0]    tube_cnt;
  logic [9:0]    ring_cnt;
  logic [9:0]    ang_a;
  logic [9:0]    ang_b;
  logic [IW-1:0] rd_addr;
  logic          rd_oob;

  // trig rom port
  logic [9:0]                rom_addr;
  tpr_pkg::trig_ctl_t        rom_ctl;
  tpr_pkg::trig_ctl_t        rom_ctl_q;
  logic signed [TW-1:0]      sin_q;
  logic signed [TW-1:0]      cos_q;

  // point engine and frame ram
  tpr_pkg::pt_write_t pt_wr;
  logic               front_busy;
  logic               pipe_busy;
  logic               mem_busy;
  logic [3:0]         rd_shade;
  logic               clr_we;

  logic accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // rom address: rotation angles, then the tube angle (10 ring steps each), then ring angles
  always_comb begin
    rom_addr = 10'd0;
    if (state == ST_TRIG_A) rom_addr = ang_a;
    else if (state == ST_TRIG_B) rom_addr = ang_b;
    else if (state == ST_TUBE_RD) rom_addr = 10'(tube_cnt) * 10'd10;
    else if (state == ST_SWEEP) rom_addr = ring_cnt;
  end

  assign rom_ctl.load_a = (state == ST_TRIG_A);
  assign rom_ctl.load_b = (state == ST_TRIG_B);
  assign rom_ctl.load_t = (state == ST_TUBE_RD);
  assign rom_ctl.point  = (state == ST_SWEEP);
  assign clr_we         = (state == ST_CLEAR);

  tpr_trig_rom #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rom (
    .clk   (clk),
    .rst   (rst),
    .addr  (rom_addr),
    .ctl   (rom_ctl),
    .sin_q (sin_q),
    .cos_q (cos_q),
    .ctl_q (rom_ctl_q)
  );

  tpr_point_pipe #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rom_ctl_q),
    .sin_v      (sin_q),
    .cos_v      (cos_q),
    .wr         (pt_wr),
    .front_busy (front_busy),
    .busy       (pipe_busy)
  );

  tpr_frame_mem #(
    .CELLS (CELLS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .clr_we   (clr_we),
    .clr_addr (IW'(clr_cnt)),
    .wr       (pt_wr),
    .rd_addr  (rd_addr),
    .rd_shade (rd_shade),
    .busy     (mem_busy)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      boot         <= 1'b1;
      clr_cnt      <= '0;
      tube_cnt     <= '0;
      ring_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.operation == tpr_pkg::OP_RENDER) begin
              boot    <= 1'b0;
              clr_cnt <= '0;
              state   <= ST_CLEAR;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) begin
            clr_cnt <= '0;
            state   <= boot ? ST_IDLE : ST_TRIG_A;
          end
        end
        ST_TRIG_A: state <= ST_TRIG_B;
        ST_TRIG_B: state <= ST_ROT;
        ST_ROT:    state <= ST_TUBE_RD;
        ST_TUBE_RD: state <= ST_TUBE_WAIT;
        // tube constants settle in the cycle after the tube angle loads
        ST_TUBE_WAIT: state <= ST_SWEEP;
        ST_SWEEP: begin
          ring_cnt <= ring_cnt + 10'd1;
          if (ring_cnt == tpr_pkg::RING_LAST) begin
            ring_cnt <= '0;
            state    <= ST_DRAIN;
          end
        end
        // points still using this tube's constants must clear the front stages
        ST_DRAIN: begin
          if (!front_busy) begin
            if (tube_cnt == tpr_pkg::TUBE_LAST) begin
              tube_cnt <= '0;
              state    <= ST_FLUSH;
            end else begin
              tube_cnt <= tube_cnt + 6'd1;
              state    <= ST_TUBE_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (!pipe_busy && !mem_busy) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_READ:     state <= ST_READ_OUT;
        ST_READ_OUT: begin
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request payload capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ang_a   <= req.angle_a;
      ang_b   <= req.angle_b;
      rd_addr <= IW'(req.cell_index);
      rd_oob  <= (16'(req.cell_index) >= 16'(CELLS));
    end
    if (state == ST_FLUSH) begin
      result.cell_char  <= 7'd0;
      result.frame_done <= 1'b1;
    end else if (state == ST_READ_OUT) begin
      result.cell_char  <= rd_oob ? tpr_pkg::SPACE_CHAR : tpr_pkg::shade_char(rd_shade);
      result.frame_done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tpr_frame_checker.sv */
// request/result checker for the torus point raster frame core: predicts each result
// depends on tpr_pkg (req_t, rsp_t, op codes); watches the block's ports only
`default_nettype none

module tpr_frame_checker #(
  parameter int COLS      = 100,
  parameter int ROWS      = 40,
  parameter int FRAC_BITS = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire tpr_pkg::req_t req,
  input  wire logic          result_valid,
  input  wire tpr_pkg::rsp_t result,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpr_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam longint unsigned ANG_PI = 64'd3373259426;
  localparam longint unsigned ANG_TWO_PI = 64'd6746518852;
  localparam longint unsigned ANG_HALF_PI = 64'd1686629713;

  logic [15:0] zbuf [NCELLS];
  logic [3:0]  shade_mem [NCELLS];
  longint      sine_lut [629];
  longint      cosine_lut [629];
  rsp_t        pending_rsp [$];

  // rounded sine in Q(FRAC_BITS) of a Q30 angle, taylor series after folding
  function automatic longint q30_sine(input longint unsigned ang);
    longint unsigned a, a2, t, acc, q;
    logic flip;
    a = ang % ANG_TWO_PI;
    flip = 1'b0;
    if (a >= ANG_PI) begin
      flip = 1'b1;
      a = a - ANG_PI;
    end
    if (a > ANG_HALF_PI) a = ANG_PI - a;
    a2 = (a * a) >> 30;
    t = a;
    acc = a;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - t;
      else acc = acc + t;
    end
    q = (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return flip ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned centi_to_q30(input longint unsigned n);
    return (n << 30) / 100;
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    return (a * b) / (longint'(1) << FRAC_BITS);
  endfunction

  function automatic logic [6:0] glyph(input logic [3:0] code);
    string ramp;
    ramp = ".,-~:;=!*#$@";
    if (code > SHADE_MAX) return 7'h20;
    return 7'(ramp[code]);
  endfunction

  // clear both stores and sweep the whole torus surface into them
  task automatic render_frame(input logic [9:0] ang_a, input logic [9:0] ang_b);
    longint one, scl, sa, ca, sb, cb, sasb, sacb, casb, cacb;
    longint st, ct, cx, cy, sp, cp, x, y, z, ooz, xp, yp, l, lum;
    int pos;
    one = longint'(1) << FRAC_BITS;
    scl = longint'(1) << (FRAC_BITS + 16);
    for (int i = 0; i < NCELLS; i++) begin
      zbuf[i] = '0;
      shade_mem[i] = BLANK_CODE;
    end
    sa = q30_sine(centi_to_q30(ang_a));
    ca = q30_sine(centi_to_q30(ang_a) + ANG_HALF_PI);
    sb = q30_sine(centi_to_q30(ang_b));
    cb = q30_sine(centi_to_q30(ang_b) + ANG_HALF_PI);
    sasb = fmul(sa, sb);
    sacb = fmul(sa, cb);
    casb = fmul(ca, sb);
    cacb = fmul(ca, cb);
    for (int t = 0; t < 63; t++) begin
      st = sine_lut[t * 10];
      ct = cosine_lut[t * 10];
      cx = ct + 2 * one;
      cy = st;
      for (int r = 0; r < 629; r++) begin
        sp = sine_lut[r];
        cp = cosine_lut[r];
        x = fmul(cx, fmul(cb, cp) + fmul(sasb, sp)) - fmul(cy, casb);
        y = fmul(cx, fmul(sb, cp) - fmul(sacb, sp)) + fmul(cy, cacb);
        z = 5 * one + fmul(fmul(ca, cx), sp) + fmul(cy, sa);
        if (z <= 0) continue;
        ooz = scl / z;
        if (ooz > 65535) ooz = 65535;
        xp = (longint'(COLS / 2) * scl + 40 * x * ooz) / scl;
        yp = (longint'(ROWS / 2) * scl - 20 * y * ooz) / scl;
        if (!(yp > 0 && yp < ROWS && xp > 0 && xp < COLS)) continue;
        pos = int'(xp + longint'(COLS) * yp);
        // depth test: only nearer points replace what is stored
        if (ooz <= longint'(zbuf[pos])) continue;
        l = fmul(fmul(cp, ct), sb) - fmul(fmul(ca, ct), sp) - fmul(sa, st)
            + fmul(cb, fmul(ca, st) - fmul(fmul(ct, sa), sp));
        lum = (8 * l) / one;
        if (lum < 0) lum = 0;
        if (lum > 11) lum = 11;
        zbuf[pos] = 16'(ooz);
        shade_mem[pos] = 4'(lum);
      end
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    for (int n = 0; n < 629; n++) begin
      sine_lut[n] = q30_sine(centi_to_q30(n));
      cosine_lut[n] = q30_sine(centi_to_q30(n) + ANG_HALF_PI);
    end
    for (int i = 0; i < NCELLS; i++) begin
      zbuf[i] = '0;
      shade_mem[i] = BLANK_CODE;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (result_valid) begin
        if (pending_rsp.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result char=%h done=%b", result.cell_char, result.frame_done);
        end else begin
          want = pending_rsp.pop_front();
          if (want.cell_char !== result.cell_char || want.frame_done !== result.frame_done) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result mismatch: exp char=%h done=%b, got char=%h done=%b",
                       want.cell_char, want.frame_done, result.cell_char, result.frame_done);
          end
        end
      end
      if (start && !busy) begin
        if (req.operation == OP_RENDER) begin
          render_frame(req.angle_a, req.angle_b);
          want.cell_char = '0;
          want.frame_done = 1'b1;
        end else begin
          want.frame_done = 1'b0;
          want.cell_char = (req.cell_index < NCELLS) ? glyph(shade_mem[req.cell_index])
                                                     : 7'h20;
        end
        pending_rsp.push_back(want);
      end
    end
    outstanding = pending_rsp.size();
  end

endmodule

`default_nettype wire

/* tb/sv/tb_torus_point_raster_frame_core.sv */
// testbench top for torus_point_raster_frame_core: clock, reset, request stimulus, verdict
// depends on tpr_pkg, the core and tpr_frame_checker
`default_nettype none

module tb_torus_point_raster_frame_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tpr_pkg::*;

  // even a run made only of renders stays far inside this cycle limit
  localparam int CYCLE_LIMIT = 20000000;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  req_t  req;
  logic  result_valid;
  rsp_t  result;
  int    mismatches;
  int    outstanding;
  int    cycles;

  torus_point_raster_frame_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .result_valid(result_valid), .result(result)
  );

  tpr_frame_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // hand one request to the core; gap is the idle time in front of it
  task automatic send_request(input req_t r, input int gap);
    logic taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    // busy is stable at the falling edge, so the next rising edge decides acceptance
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic req_t render_req(input logic [9:0] a, input logic [9:0] b);
    req_t r;
    r = '0;
    r.operation = OP_RENDER;
    r.angle_a = a;
    r.angle_b = b;
    r.cell_index = 12'($urandom);  // ignored by render, toggled anyway
    return r;
  endfunction

  function automatic req_t read_req(input logic [11:0] idx);
    req_t r;
    r.operation = OP_READ;
    r.angle_a = 10'($urandom);
    r.angle_b = 10'($urandom);
    r.cell_index = idx;
    return r;
  endfunction

  // mostly cells where the torus lands, some anywhere, some past the screen
  function automatic logic [11:0] pick_cell();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 12'($urandom_range(5, 35) * 100 + $urandom_range(20, 80));
    if (sel < 9) return 12'($urandom_range(0, 3999));
    return 12'($urandom_range(3990, 4095));
  endfunction

  initial begin
    int gap;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reads before any render, all blank
    send_request(read_req(12'd0), 0);
    send_request(read_req(12'd2050), 1);
    send_request(read_req(12'd4095), 0);
    // plain pose, then read around the middle rows
    send_request(render_req(10'd0, 10'd0), 2);
    for (int i = 0; i < 5; i++) send_request(read_req(12'(2000 + 10 * i + 30)), i % 3);
    send_request(read_req(12'd3999), 0);
    send_request(read_req(12'd4000), 0);
    // largest in-range angles
    send_request(render_req(10'd628, 10'd628), 0);
    for (int i = 0; i < 3; i++) send_request(read_req(12'(1850 + 7 * i)), 0);
    // angles beyond 2*pi, every angle bit high
    send_request(render_req(10'h3FF, 10'h3FF), 3);
    send_request(read_req(12'd2049), 0);
    send_request(render_req(10'd314, 10'd157), 1);
    for (int i = 0; i < 3; i++) send_request(read_req(12'(1545 + 101 * i)), 0);

    // random part
    for (int n = 0; n < 80; n++) begin
      // back-to-back stretch in the middle, random gaps elsewhere
      gap = (n >= 30 && n < 45) ? 0 : $urandom_range(0, 5);
      // drain everything before going on
      if (n == 60) begin
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if ($urandom_range(0, 14) == 0) begin
        if ($urandom_range(0, 3) == 0)
          send_request(render_req(10'($urandom), 10'($urandom)), gap);
        else
          send_request(render_req(10'($urandom_range(0, 628)), 10'($urandom_range(0, 628))),
                       gap);
      end else begin
        send_request(read_req(pick_cell()), gap);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
